@@ src/cigar_soft_clip_histogram_assert.svh @@
// Assertion macros shared by the histogram modules.
`ifndef CIGAR_SOFT_CLIP_HISTOGRAM_ASSERT_SVH
`define CIGAR_SOFT_CLIP_HISTOGRAM_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CSH_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("csh assertion failed");

// Check that cons holds in the cycle after ante.
`define CSH_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("csh assertion failed");

`endif

@@ src/csh_pkg.sv @@
`default_nettype none
package csh_pkg;

   localparam int MAX_BINS = 256;
   localparam int BIN_AW   = $clog2(MAX_BINS);

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 144;

   localparam logic [15:0] LEN_MAX = 16'hFFFF;
   localparam logic [31:0] BIN_MAX = 32'hFFFF_FFFF;

   localparam int FLAG_UNMAPPED_BIT  = 2;
   localparam int FLAG_SECONDARY_BIT = 8;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_S    = 8'h53;
   localparam logic [7:0] CH_M    = 8'h4D;
   localparam logic [7:0] CH_N    = 8'h4E;
   localparam logic [7:0] CH_I    = 8'h49;
   localparam logic [7:0] CH_D    = 8'h44;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_BIN  = 1'b1;

   localparam logic RES_SUMMARY = 1'b0;
   localparam logic RES_BIN     = 1'b1;

   localparam logic CSR_TOTAL_READS = 1'b0;
   localparam logic CSR_BINS_IN_USE = 1'b1;

   localparam logic [8:0] BINS_RESET = 9'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic char_step;
      logic close;
      logic bin_read;
      logic sweep;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic sweep_needed;
      logic sweep_done;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

@@ src/csh_ram.sv @@
`default_nettype none
module csh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ src/csh_datapath.sv @@
`default_nettype none
`include "cigar_soft_clip_histogram_assert.svh"
module csh_datapath
   import csh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [7:0]  cigar_char,
   input  wire logic [11:0] sam_flag,
   input  wire logic [7:0]  bin_index,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output logic             result_kind,
   output logic [15:0]      head_clip,
   output logic [15:0]      tail_clip,
   output logic [8:0]       clip_total,
   output logic             record_counted,
   output logic [31:0]      primary_total,
   output logic [32:0]      unmapped_total,
   output logic [31:0]      bin_value
);

   logic [31:0] total_reads_ff;
   logic [8:0]  bins_ff;

   logic [15:0] num_ff, num_in;
   logic        op_seen_ff, op_seen_in;
   logic [15:0] head_ff, head_in;
   logic        last_clip_ff, last_clip_in;
   logic [15:0] last_len_ff, last_len_in;
   logic [31:0] primary_ff;

   logic [15:0] sum_head_ff, sum_head;
   logic [15:0] sum_tail_ff, sum_tail;
   logic [8:0]  sum_total_ff, sum_total;
   logic        sum_counted_ff, sum_counted;
   logic        kind_ff;
   logic        bin_hit_ff;

   logic [8:0]        ptr_ff;
   logic              wr_pend_ff;
   logic [BIN_AW-1:0] wr_addr_ff;
   logic              wr_vld_ff;
   logic [MAX_BINS-1:0] valid_ff;

   logic              issue;
   logic              rd_en;
   logic [BIN_AW-1:0] rd_addr;
   logic [31:0]       rd_data;
   logic [31:0]       wr_data;

   logic              rsp_valid_ff;
   logic              out_kind_ff;
   logic [15:0]       out_head_ff;
   logic [15:0]       out_tail_ff;
   logic [8:0]        out_total_ff;
   logic              out_counted_ff;
   logic [31:0]       out_primary_ff;
   logic [32:0]       out_unmapped_ff;
   logic [31:0]       out_bin_ff;

   logic        is_digit;
   logic        is_op;
   logic        is_clip;
   logic [19:0] num_ten;
   logic [19:0] num_next;
   logic [16:0] total_wide;
   logic [8:0]  limit;

   // Parse one character.
   always_comb begin
      is_digit   = (cigar_char >= CH_ZERO) && (cigar_char <= CH_NINE);
      is_clip    = (cigar_char == CH_S);
      is_op      = is_clip || (cigar_char == CH_M) || (cigar_char == CH_N) ||
                   (cigar_char == CH_I) || (cigar_char == CH_D);
      num_ten    = 20'({num_ff, 3'b000}) + 20'({num_ff, 1'b0});
      num_next   = num_ten + 20'(cigar_char[3:0]);
      num_in       = num_ff;
      op_seen_in   = op_seen_ff;
      head_in      = head_ff;
      last_clip_in = last_clip_ff;
      last_len_in  = last_len_ff;
      if (is_digit) begin
         num_in = (num_next > 20'(LEN_MAX)) ? LEN_MAX : num_next[15:0];
      end else if (is_op) begin
         if (!op_seen_ff) begin
            head_in    = is_clip ? num_ff : 16'd0;
            op_seen_in = 1'b1;
         end
         last_clip_in = is_clip;
         last_len_in  = num_ff;
         num_in       = 16'd0;
      end else begin
         num_in = 16'd0;
      end
   end

   // Summarize the record from the post-character state.
   always_comb begin
      sum_head    = op_seen_in ? head_in : 16'd0;
      sum_tail    = (op_seen_in && last_clip_in) ? last_len_in : 16'd0;
      limit       = (int'(bins_ff) > MAX_BINS) ? 9'(MAX_BINS) : bins_ff;
      total_wide  = 17'(sum_head) + 17'(sum_tail);
      sum_total   = (total_wide > 17'(limit)) ? limit : total_wide[8:0];
      sum_counted = !sam_flag[FLAG_UNMAPPED_BIT] && !sam_flag[FLAG_SECONDARY_BIT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_reads_ff <= '0;
         bins_ff        <= BINS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_READS: total_reads_ff <= csr_data;
            CSR_BINS_IN_USE: bins_ff        <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= '0;
         op_seen_ff   <= 1'b0;
         head_ff      <= '0;
         last_clip_ff <= 1'b0;
         last_len_ff  <= '0;
         primary_ff   <= '0;
      end else if (cmd.char_step) begin
         if (cmd.close) begin
            num_ff       <= '0;
            op_seen_ff   <= 1'b0;
            head_ff      <= '0;
            last_clip_ff <= 1'b0;
            last_len_ff  <= '0;
            primary_ff   <= primary_ff + 32'(sum_counted);
         end else begin
            num_ff       <= num_in;
            op_seen_ff   <= op_seen_in;
            head_ff      <= head_in;
            last_clip_ff <= last_clip_in;
            last_len_ff  <= last_len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.close) begin
         sum_head_ff    <= sum_head;
         sum_tail_ff    <= sum_tail;
         sum_total_ff   <= sum_total;
         sum_counted_ff <= sum_counted;
         kind_ff        <= RES_SUMMARY;
      end else if (cmd.bin_read) begin
         kind_ff    <= RES_BIN;
         bin_hit_ff <= (int'(bin_index) < MAX_BINS) && valid_ff[BIN_AW'(bin_index)];
      end
   end

   // Sweep: read bin k while writing bin k-1.
   assign issue   = cmd.sweep && (ptr_ff != sum_total_ff);
   assign rd_en   = cmd.bin_read || issue;
   assign rd_addr = cmd.bin_read ? BIN_AW'(bin_index) : BIN_AW'(ptr_ff);
   assign wr_data = !wr_vld_ff ? 32'd1 :
                    (rd_data == BIN_MAX) ? rd_data : rd_data + 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         wr_pend_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         if (cmd.close) begin
            ptr_ff <= '0;
         end else if (issue) begin
            ptr_ff <= ptr_ff + 9'd1;
         end
         wr_pend_ff <= issue;
         if (wr_pend_ff) begin
            valid_ff[wr_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         wr_addr_ff <= rd_addr;
         wr_vld_ff  <= valid_ff[rd_addr];
      end
   end

   csh_ram #(
      .WIDTH(32),
      .DEPTH(MAX_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_pend_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_kind_ff     <= kind_ff;
         out_primary_ff  <= primary_ff;
         out_unmapped_ff <= 33'(total_reads_ff) - 33'(primary_ff);
         if (kind_ff == RES_BIN) begin
            out_head_ff    <= '0;
            out_tail_ff    <= '0;
            out_total_ff   <= '0;
            out_counted_ff <= 1'b0;
            out_bin_ff     <= bin_hit_ff ? rd_data : 32'd0;
         end else begin
            out_head_ff    <= sum_head_ff;
            out_tail_ff    <= sum_tail_ff;
            out_total_ff   <= sum_total_ff;
            out_counted_ff <= sum_counted_ff;
            out_bin_ff     <= '0;
         end
      end
   end

   assign stat.sweep_needed = sum_counted && (sum_total != 9'd0);
   assign stat.sweep_done   = (ptr_ff == sum_total_ff) && !wr_pend_ff;
   assign stat.out_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign result_kind    = out_kind_ff;
   assign head_clip      = out_head_ff;
   assign tail_clip      = out_tail_ff;
   assign clip_total     = out_total_ff;
   assign record_counted = out_counted_ff;
   assign primary_total  = out_primary_ff;
   assign unmapped_total = out_unmapped_ff;
   assign bin_value      = out_bin_ff;

   `CSH_ASSERT_SAME(a_dp_wr_range, wr_pend_ff, int'(wr_addr_ff) < int'(sum_total_ff))
   `CSH_ASSERT_NEXT(a_dp_primary_hold, !cmd.close, $stable(primary_ff))
   `CSH_ASSERT_NEXT(a_dp_load_valid, cmd.load, rsp_valid_ff)

endmodule
`default_nettype wire

@@ src/csh_ctrl.sv @@
`default_nettype none
`include "cigar_soft_clip_histogram_assert.svh"
module csh_ctrl
   import csh_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_kind,
   input  wire logic     req_last,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               if (req_kind == REQ_BIN) begin
                  cmd.bin_read = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  cmd.char_step = 1'b1;
                  if (req_last) begin
                     cmd.close = 1'b1;
                     state_in  = stat.sweep_needed ? ST_SWEEP : ST_EMIT;
                  end
               end
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `CSH_ASSERT_NEXT(a_ctrl_sweep_entry, cmd.close && stat.sweep_needed, state_ff == ST_SWEEP)
   `CSH_ASSERT_NEXT(a_ctrl_sweep_exit, state_ff == ST_SWEEP && stat.sweep_done, state_ff == ST_EMIT)
   `CSH_ASSERT_SAME(a_ctrl_ready_idle, req_ready, state_ff == ST_IDLE)

endmodule
`default_nettype wire

@@ src/cigar_soft_clip_histogram.sv @@
// Plain CIGAR characters keep ST_IDLE; the next one is taken in the following cycle.
// Bin reads and unswept record ends load their result from ST_EMIT, which waits while rsp stalls.
// A counted record end with nonzero clip_total does the read-modify-write pass over the bins.
// A new request is taken only once the previous result has been loaded into the output register.
// Synchronous reset clears control state, counters and bin valid flags, and resets config.
`default_nettype none
module cigar_soft_clip_histogram
   import csh_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // cigar_char[7:0], sam_flag[19:8], bin_index[27:20], zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type
   input  wire logic                   req_tuser,
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // head_clip[15:0], tail_clip[31:16], clip_total[40:32], record_counted[41],
   // primary_total[73:42], unmapped_total[106:74], bin_value[138:107], zero pad
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // result_kind
   output logic                        rsp_tuser,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_index,
   input  wire logic [31:0]            csr_data
);

   cmd_type  cmd;
   stat_type stat;

   logic [15:0] head_clip;
   logic [15:0] tail_clip;
   logic [8:0]  clip_total;
   logic        record_counted;
   logic [31:0] primary_total;
   logic [32:0] unmapped_total;
   logic [31:0] bin_value;

   assign csr_ready = 1'b1;

   csh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_last  (req_tlast),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   csh_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .cigar_char     (req_tdata[7:0]),
      .sam_flag       (req_tdata[19:8]),
      .bin_index      (req_tdata[27:20]),
      .csr_we         (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .result_kind    (rsp_tuser),
      .head_clip      (head_clip),
      .tail_clip      (tail_clip),
      .clip_total     (clip_total),
      .record_counted (record_counted),
      .primary_total  (primary_total),
      .unmapped_total (unmapped_total),
      .bin_value      (bin_value)
   );

   assign rsp_tdata = {5'd0, bin_value, unmapped_total, primary_total, record_counted,
                       clip_total, tail_clip, head_clip};

endmodule
`default_nettype wire
